/* rtl/pdc_pkg.sv */
// Package for the Porter-Duff pixel compositor.
// Holds the operator codes, the lane operand struct and the rounded divide-by-255 helper.
// No dependencies.
package pdc_pkg;

	// Operator codes of the blend_operator register.
	typedef enum logic [2:0] {
		OP_OVER = 3'd0,
		OP_IN   = 3'd1,
		OP_OUT  = 3'd2,
		OP_ATOP = 3'd3,
		OP_XOR  = 3'd4
	} pdc_op_t;

	// Two product terms that one lane adds after rounding each one.
	typedef struct packed {
		logic [7:0] a1;
		logic [7:0] b1;
		logic [7:0] a2;
		logic [7:0] b2;
	} pdc_operands_t;

	// Result pixel as it leaves the pipeline.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pdc_pixel_t;

	// Rounded x/255 for a product of two 8-bit values.
	// With y = x + 127 the shift-add form equals floor(y/255) for all y below 65535.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] y;
		logic [16:0] t;
		y = 17'(x) + 17'd127;
		t = y + (y >> 8) + 17'd1;
		return t[15:8];
	endfunction

endpackage

/* rtl/pdc_if.sv */
// Channel interfaces of the Porter-Duff pixel compositor: pixel pair in, pixel out, config.
// Each carries valid, ready and its payload. No dependencies.

interface pdc_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] src_alpha;
	logic [7:0] dst_red;
	logic [7:0] dst_green;
	logic [7:0] dst_blue;
	logic [7:0] dst_alpha;

	modport source (
		output valid, src_red, src_green, src_blue, src_alpha,
		output dst_red, dst_green, dst_blue, dst_alpha,
		input  ready
	);
	modport sink (
		input  valid, src_red, src_green, src_blue, src_alpha,
		input  dst_red, dst_green, dst_blue, dst_alpha,
		output ready
	);
endinterface

interface pdc_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface pdc_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] blend_operator;

	modport source (output valid, blend_operator, input ready);
	modport sink (input valid, blend_operator, output ready);
endinterface

/* rtl/pdc_lane.sv */
// One compositing lane: two 8x8 products, each rounded by 255, then summed.
// Depends on pdc_pkg (operand struct, div255).
module pdc_lane
	import pdc_pkg::*;
(
	input  logic          clk,
	input  logic          en,
	input  pdc_operands_t ops,
	output logic [8:0]    chan_sum
);

	logic [15:0] p1_s3;
	logic [15:0] p2_s3;
	logic [8:0]  sum_s4;

	// Products are registered before the rounding divide.
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s3  <= 16'(ops.a1) * 16'(ops.b1);
			p2_s3  <= 16'(ops.a2) * 16'(ops.b2);
			sum_s4 <= 9'(div255(p1_s3)) + 9'(div255(p2_s3));
		end
	end

	assign chan_sum = sum_s4;

endmodule

/* rtl/pdc_unpremul.sv */
// Unpremultiply for one color channel: saturating rounded (C*255 + A/2) / A.
// Restoring division, one quotient bit per pipeline stage. Depends on nothing.
module pdc_unpremul (
	input  logic       clk,
	input  logic       en,
	input  logic [8:0] chan,
	input  logic [8:0] alpha,
	output logic [7:0] value
);

	logic [16:0] rem_s [0:8];
	logic [7:0]  quo_s [0:8];
	logic [8:0]  dvs_s [0:8];
	logic        sat_s [0:8];

	logic [16:0] num_d;

	// Numerator with the rounding half of the divisor folded in.
	assign num_d = ({chan, 8'd0} - 17'(chan)) + 17'(alpha >> 1);

	// Entry stage: a quotient of 256 or more saturates.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_d;
			quo_s[0] <= '0;
			dvs_s[0] <= alpha;
			sat_s[0] <= (num_d >= {alpha, 8'd0});
		end
	end

	// One compare and subtract per stage, most significant bit first.
	for (genvar g = 0; g < 8; g++) begin : g_step
		localparam int Shift = 7 - g;
		logic [16:0] trial_d;
		logic        fits_d;

		assign trial_d = 17'(dvs_s[g]) << Shift;
		assign fits_d  = (rem_s[g] >= trial_d);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= fits_d ? (rem_s[g] - trial_d) : rem_s[g];
				quo_s[g+1] <= {quo_s[g][6:0], fits_d};
				dvs_s[g+1] <= dvs_s[g];
				sat_s[g+1] <= sat_s[g];
			end
		end
	end

	assign value = sat_s[8] ? 8'd255 : quo_s[8];

endmodule

/* rtl/porter_duff_pixel_compositor.sv */
// Top level of the Porter-Duff pixel compositor.
// Depends on pdc_pkg, the channel interfaces in pdc_if, pdc_lane and pdc_unpremul.
//
// Usage:
// pix_in carries one source and one destination RGBA pixel (straight alpha) per
// transaction; pix_out returns the composed pixel, straight alpha, one per input.
// cfg writes blend_operator (0 over, 1 in, 2 out, 3 atop, 4 xor, others act as over);
// it is always ready and should only be written while no pixel is in flight.
// Throughput is one pixel per clock while pix_out is ready. The pixel passes fourteen
// registers, the first loaded at the accepting edge: two premultiply stages, two lane
// stages, one numerator stage, eight stages of the bit-per-stage unpremultiply divider,
// and the output register.
// Reset clears all valid flags and sets the operator to over.
// When pix_out stalls, the output register holds its pixel and one more pixel goes
// into a skid register; pix_in.ready then drops and the pipeline freezes until the
// skid register drains.
module porter_duff_pixel_compositor
	import pdc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	pdc_pix_in_if.sink    pix_in,
	pdc_pix_out_if.source pix_out,
	pdc_cfg_if.sink       cfg
);

	localparam int Last = 13;

	pdc_op_t       op_q;
	logic          en;
	logic          accept;
	logic          vld_s [1:Last];

	logic [7:0]    src_c [0:2];
	logic [7:0]    dst_c [0:2];
	logic [15:0]   src_prod_s1 [0:2];
	logic [15:0]   dst_prod_s1 [0:2];
	logic [7:0]    sa_s1, da_s1;
	pdc_op_t       op_s1;
	logic [7:0]    s_s2 [0:2];
	logic [7:0]    d_s2 [0:2];
	logic [7:0]    sa_s2, da_s2;
	pdc_op_t       op_s2;
	logic [7:0]    ns_d, nd_d;

	pdc_operands_t ops_d [0:3];
	logic [8:0]    sum_d [0:3];
	logic [7:0]    chan_d [0:2];

	logic [7:0]    alpha_s [5:Last];
	logic          zero_s [5:Last];

	pdc_pixel_t    pix_d;
	pdc_pixel_t    out_q;
	pdc_pixel_t    skid_q;
	logic          out_vld_q;
	logic          skid_vld_q;
	logic          take;
	logic          push;

	// Configuration register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_OVER;
		end else if (cfg.valid) begin
			op_q <= pdc_op_t'(cfg.blend_operator);
		end
	end

	// The pipeline advances as long as the skid register is free.
	assign en            = !skid_vld_q;
	assign pix_in.ready  = en;
	assign accept        = pix_in.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= Last; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= accept;
			for (int i = 2; i <= Last; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Premultiply: product in the first stage, rounded divide in the second.
	assign src_c[0] = pix_in.src_red;
	assign src_c[1] = pix_in.src_green;
	assign src_c[2] = pix_in.src_blue;
	assign dst_c[0] = pix_in.dst_red;
	assign dst_c[1] = pix_in.dst_green;
	assign dst_c[2] = pix_in.dst_blue;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				src_prod_s1[i] <= 16'(src_c[i]) * 16'(pix_in.src_alpha);
				dst_prod_s1[i] <= 16'(dst_c[i]) * 16'(pix_in.dst_alpha);
				s_s2[i]        <= div255(src_prod_s1[i]);
				d_s2[i]        <= div255(dst_prod_s1[i]);
			end
			sa_s1 <= pix_in.src_alpha;
			da_s1 <= pix_in.dst_alpha;
			op_s1 <= op_q;
			sa_s2 <= sa_s1;
			da_s2 <= da_s1;
			op_s2 <= op_s1;
		end
	end

	// Operator select: each lane gets two product terms; a factor of 255 passes
	// a value through unchanged and a zero factor drops the term.
	assign ns_d = ~sa_s2;
	assign nd_d = ~da_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (op_s2)
				OP_IN: begin
					ops_d[i] = '{a1: s_s2[i], b1: da_s2, a2: 8'd0, b2: 8'd0};
				end
				OP_OUT: begin
					ops_d[i] = '{a1: s_s2[i], b1: nd_d, a2: 8'd0, b2: 8'd0};
				end
				OP_ATOP: begin
					ops_d[i] = '{a1: s_s2[i], b1: da_s2, a2: ns_d, b2: d_s2[i]};
				end
				OP_XOR: begin
					ops_d[i] = '{a1: nd_d, b1: s_s2[i], a2: ns_d, b2: d_s2[i]};
				end
				default: begin
					ops_d[i] = '{a1: s_s2[i], b1: 8'd255, a2: ns_d, b2: d_s2[i]};
				end
			endcase
		end
		case (op_s2)
			OP_IN: begin
				ops_d[3] = '{a1: sa_s2, b1: da_s2, a2: 8'd0, b2: 8'd0};
			end
			OP_OUT: begin
				ops_d[3] = '{a1: sa_s2, b1: nd_d, a2: 8'd0, b2: 8'd0};
			end
			OP_ATOP: begin
				ops_d[3] = '{a1: da_s2, b1: 8'd255, a2: 8'd0, b2: 8'd0};
			end
			OP_XOR: begin
				ops_d[3] = '{a1: nd_d, b1: sa_s2, a2: ns_d, b2: da_s2};
			end
			default: begin
				ops_d[3] = '{a1: sa_s2, b1: 8'd255, a2: ns_d, b2: da_s2};
			end
		endcase
	end

	// Three color lanes and one alpha lane.
	for (genvar l = 0; l < 4; l++) begin : g_lane
		pdc_lane u_lane (
			.clk      (clk),
			.en       (en),
			.ops      (ops_d[l]),
			.chan_sum (sum_d[l])
		);
	end

	// Unpremultiply each color by the composed alpha.
	for (genvar l = 0; l < 3; l++) begin : g_unpremul
		pdc_unpremul u_unpremul (
			.clk   (clk),
			.en    (en),
			.chan  (sum_d[l]),
			.alpha (sum_d[3]),
			.value (chan_d[l])
		);
	end

	// Saturated alpha and the zero-alpha flag travel beside the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s[5] <= (sum_d[3] > 9'd255) ? 8'd255 : sum_d[3][7:0];
			zero_s[5]  <= (sum_d[3] == 9'd0);
			for (int i = 6; i <= Last; i++) begin
				alpha_s[i] <= alpha_s[i-1];
				zero_s[i]  <= zero_s[i-1];
			end
		end
	end

	// Merge the lanes into one pixel; a zero alpha forces all fields to zero.
	always_comb begin
		if (zero_s[Last]) begin
			pix_d = '0;
		end else begin
			pix_d = '{red: chan_d[0], green: chan_d[1], blue: chan_d[2],
				alpha: alpha_s[Last]};
		end
	end

	// Output register with a skid register behind it.
	assign take = out_vld_q && pix_out.ready;
	assign push = en && vld_s[Last];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_vld_q || take) begin
				out_q <= pix_d;
			end else begin
				skid_q <= pix_d;
			end
		end
	end

	assign pix_out.valid     = out_vld_q;
	assign pix_out.out_red   = out_q.red;
	assign pix_out.out_green = out_q.green;
	assign pix_out.out_blue  = out_q.blue;
	assign pix_out.out_alpha = out_q.alpha;

endmodule
